@@ hw/rtl/uer_pkg.sv @@
// Shared types and constants for the ultrasonic echo ranger.
`default_nettype none
package uer_pkg;

	localparam int COUNT_BITS = 16;
	localparam int CMP_W      = (COUNT_BITS > 16) ? COUNT_BITS : 16;
	localparam int Q_DEPTH    = 4;
	localparam int Q_AW       = $clog2(Q_DEPTH);
	localparam int DIV_STEPS  = 16;
	localparam int DIV_CW     = $clog2(DIV_STEPS + 1);

	localparam logic [15:0] TICKS_PER_CM_RST   = 16'd116;
	localparam logic [7:0]  TRIGGER_LENGTH_RST = 8'd20;
	localparam logic [15:0] TIMEOUT_LIMIT_RST  = 16'hFFFF;

	localparam int PADDR_W = 4;
	localparam logic [1:0] REG_TICKS_PER_CM   = 2'd0;
	localparam logic [1:0] REG_TRIGGER_LENGTH = 2'd1;
	localparam logic [1:0] REG_TIMEOUT_LIMIT  = 2'd2;

	typedef struct packed {
		logic echo_level;
		logic start_request;
		logic abort_request;
	} cmd_t;

	typedef struct packed {
		logic        trigger_level;
		logic        busy_res;
		logic        done_pulse;
		logic        timed_out;
		logic        complete_flag;
		logic [15:0] echo_width;
		logic [15:0] distance;
	} res_t;

	typedef struct packed {
		logic        trigger_level;
		logic        busy_res;
		logic        done_pulse;
		logic        timed_out;
		logic        complete_flag;
		logic [15:0] echo_width;
	} rec_t;

	typedef struct packed {
		logic [15:0] ticks_per_cm;
		logic [7:0]  trigger_length;
		logic [15:0] timeout_limit;
	} cfg_t;

endpackage
`default_nettype wire

@@ hw/rtl/ultrasonic_echo_ranger.sv @@
// Top level of the ultrasonic echo ranger: config registers, front, queue, back.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------
//   input    | push / full            | cmd (echo, start, abort)
//   result   | empty / pop            | res (levels, flags, width, distance)
//   config   | psel penable pwrite    | paddr, pwdata, prdata
//
// One result per item. The front takes one tick item per cycle while the queue has room.
// A result with a nonzero width that misses the last-result cache uses the one-bit-per-cycle
// divider; other results skip it and load the output register directly.
// Reset clears control state and loads register defaults (not data registers); no clearing pass.
// Either side may stall: the four-entry queue and the output register absorb it.
`default_nettype none
module ultrasonic_echo_ranger (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [uer_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	input  wire logic                          push,
	output logic                               full,
	input  wire uer_pkg::cmd_t                 cmd,
	output logic                               empty,
	input  wire logic                          pop,
	output uer_pkg::res_t                      res
);

	uer_pkg::cfg_t  cfg_q;
	uer_pkg::rec_t  front_rec, head_rec;
	logic           cfg_wr, accept, q_empty, q_pop;
	logic [1:0]     reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];
	assign accept  = push && !full;

	always_comb begin
		case (reg_idx)
			uer_pkg::REG_TICKS_PER_CM:   prdata = {16'd0, cfg_q.ticks_per_cm};
			uer_pkg::REG_TRIGGER_LENGTH: prdata = {24'd0, cfg_q.trigger_length};
			uer_pkg::REG_TIMEOUT_LIMIT:  prdata = {16'd0, cfg_q.timeout_limit};
			default:                     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ticks_per_cm   <= uer_pkg::TICKS_PER_CM_RST;
			cfg_q.trigger_length <= uer_pkg::TRIGGER_LENGTH_RST;
			cfg_q.timeout_limit  <= uer_pkg::TIMEOUT_LIMIT_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				uer_pkg::REG_TICKS_PER_CM:   cfg_q.ticks_per_cm   <= pwdata[15:0];
				uer_pkg::REG_TRIGGER_LENGTH: cfg_q.trigger_length <= pwdata[7:0];
				uer_pkg::REG_TIMEOUT_LIMIT:  cfg_q.timeout_limit  <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	uer_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.accept (accept),
		.cfg    (cfg_q),
		.rec    (front_rec)
	);

	uer_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (push),
		.wr_rec (front_rec),
		.full   (full),
		.rd     (q_pop),
		.rd_rec (head_rec),
		.empty  (q_empty)
	);

	uer_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rec          (head_rec),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.ticks_per_cm (cfg_q.ticks_per_cm),
		.cache_clr    (cfg_wr && (reg_idx == uer_pkg::REG_TICKS_PER_CM)),
		.pop          (pop),
		.empty        (empty),
		.res          (res)
	);

endmodule
`default_nettype wire

@@ hw/rtl/uer_front.sv @@
// Front part: per-tick ranging state machine that emits one record per item.
`default_nettype none
module uer_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire uer_pkg::cmd_t cmd,
	input  wire logic          accept,
	input  wire uer_pkg::cfg_t cfg,
	output uer_pkg::rec_t      rec
);

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_TRIG = 4'b0010,
		PH_WAIT = 4'b0100,
		PH_MEAS = 4'b1000
	} phase_t;

	phase_t                          ph_q, ph_d;
	logic [uer_pkg::COUNT_BITS-1:0]  tick_q, tick_d, tick_inc;
	logic [uer_pkg::COUNT_BITS-1:0]  rise_q, rise_d;
	logic [15:0]                     width_q, width_d;
	logic [7:0]                      trig_left_q, trig_left_d;
	logic                            cmpl_q, cmpl_d;
	logic                            done, tmo;

	assign tick_inc = tick_q + 1'b1;

	always_comb begin
		ph_d        = ph_q;
		tick_d      = tick_q;
		rise_d      = rise_q;
		width_d     = width_q;
		trig_left_d = trig_left_q;
		cmpl_d      = cmpl_q;
		done        = 1'b0;
		tmo         = 1'b0;
		if (cmd.abort_request) begin
			ph_d        = PH_IDLE;
			trig_left_d = '0;
			cmpl_d      = 1'b0;
		end else if (ph_q == PH_IDLE) begin
			if (cmd.start_request) begin
				cmpl_d      = 1'b0;
				width_d     = '0;
				tick_d      = '0;
				rise_d      = '0;
				trig_left_d = cfg.trigger_length;
				ph_d        = PH_TRIG;
			end
		end else begin
			tick_d = tick_inc;
			if (uer_pkg::CMP_W'(tick_inc) >= uer_pkg::CMP_W'(cfg.timeout_limit)) begin
				ph_d        = PH_IDLE;
				trig_left_d = '0;
				width_d     = '0;
				cmpl_d      = 1'b1;
				done        = 1'b1;
				tmo         = 1'b1;
			end else begin
				case (ph_q)
					PH_TRIG: begin
						if (trig_left_q <= 8'd1) begin
							trig_left_d = '0;
							ph_d        = PH_WAIT;
						end else begin
							trig_left_d = trig_left_q - 8'd1;
						end
					end
					PH_WAIT: begin
						if (cmd.echo_level) begin
							rise_d = tick_inc;
							ph_d   = PH_MEAS;
						end
					end
					PH_MEAS: begin
						if (!cmd.echo_level) begin
							width_d = 16'(tick_inc - rise_q);
							ph_d    = PH_IDLE;
							cmpl_d  = 1'b1;
							done    = 1'b1;
						end
					end
					default: begin
						ph_d = PH_IDLE;
					end
				endcase
			end
		end
	end

	always_comb begin
		rec.trigger_level = (ph_d == PH_TRIG);
		rec.busy_res      = (ph_d != PH_IDLE);
		rec.done_pulse    = done;
		rec.timed_out     = tmo;
		rec.complete_flag = cmpl_d;
		rec.echo_width    = width_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= PH_IDLE;
			tick_q      <= '0;
			rise_q      <= '0;
			width_q     <= '0;
			trig_left_q <= '0;
			cmpl_q      <= 1'b0;
		end else if (accept) begin
			ph_q        <= ph_d;
			tick_q      <= tick_d;
			rise_q      <= rise_d;
			width_q     <= width_d;
			trig_left_q <= trig_left_d;
			cmpl_q      <= cmpl_d;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/uer_fifo.sv @@
// Short record queue between the front and back parts.
`default_nettype none
module uer_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr,
	input  wire uer_pkg::rec_t wr_rec,
	output logic               full,
	input  wire logic          rd,
	output uer_pkg::rec_t      rd_rec,
	output logic               empty
);

	uer_pkg::rec_t             mem_q [uer_pkg::Q_DEPTH];
	logic [uer_pkg::Q_AW-1:0]  wp_q, rp_q;
	logic [uer_pkg::Q_AW:0]    cnt_q;
	logic                      do_wr, do_rd;

	assign full   = (cnt_q == (uer_pkg::Q_AW+1)'(uer_pkg::Q_DEPTH));
	assign empty  = (cnt_q == '0);
	assign do_wr  = wr && !full;
	assign do_rd  = rd && !empty;
	assign rd_rec = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/uer_back.sv @@
// Back part: distance divider with a last-result cache and the output register.
`default_nettype none
module uer_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire uer_pkg::rec_t rec,
	input  wire logic          q_empty,
	output logic               q_pop,
	input  wire logic [15:0]   ticks_per_cm,
	input  wire logic          cache_clr,
	input  wire logic          pop,
	output logic               empty,
	output uer_pkg::res_t      res
);

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_DIV  = 2'b10
	} back_state_t;

	back_state_t                  st_q;
	uer_pkg::rec_t                rec_q;
	logic [15:0]                  rem_q, quo_q, dsr_q;
	logic [uer_pkg::DIV_CW-1:0]   cnt_q;
	logic                         cache_vld_q;
	logic [15:0]                  cache_w_q, cache_d_q;
	logic                         out_vld_q;
	uer_pkg::res_t                out_q;
	logic                         out_free, need_div, load_fast, start_div, load_div;
	logic                         div_busy;
	logic [16:0]                  trial;
	logic                         ge;

	assign out_free  = !out_vld_q || pop;
	assign need_div  = (rec.echo_width != '0) &&
		!(cache_vld_q && (cache_w_q == rec.echo_width));
	assign load_fast = (st_q == B_IDLE) && !q_empty && !need_div && out_free;
	assign start_div = (st_q == B_IDLE) && !q_empty && need_div;
	assign div_busy  = (cnt_q != uer_pkg::DIV_CW'(uer_pkg::DIV_STEPS));
	assign load_div  = (st_q == B_DIV) && !div_busy && out_free;
	assign q_pop     = load_fast || start_div;

	assign trial = {rem_q, quo_q[15]};
	assign ge    = (trial >= {1'b0, dsr_q});

	assign empty = !out_vld_q;
	assign res   = out_q;

	always_ff @(posedge clk) begin
		if (start_div) begin
			rec_q <= rec;
			rem_q <= '0;
			quo_q <= rec.echo_width;
			dsr_q <= (ticks_per_cm == '0) ? 16'd1 : ticks_per_cm;
		end else if ((st_q == B_DIV) && div_busy) begin
			rem_q <= ge ? 16'(trial - {1'b0, dsr_q}) : trial[15:0];
			quo_q <= {quo_q[14:0], ge};
		end
		if (load_fast) begin
			out_q.trigger_level <= rec.trigger_level;
			out_q.busy_res      <= rec.busy_res;
			out_q.done_pulse    <= rec.done_pulse;
			out_q.timed_out     <= rec.timed_out;
			out_q.complete_flag <= rec.complete_flag;
			out_q.echo_width    <= rec.echo_width;
			out_q.distance      <= (rec.echo_width == '0) ? 16'd0 : cache_d_q;
		end else if (load_div) begin
			out_q.trigger_level <= rec_q.trigger_level;
			out_q.busy_res      <= rec_q.busy_res;
			out_q.done_pulse    <= rec_q.done_pulse;
			out_q.timed_out     <= rec_q.timed_out;
			out_q.complete_flag <= rec_q.complete_flag;
			out_q.echo_width    <= rec_q.echo_width;
			out_q.distance      <= quo_q;
		end
		if (load_div) begin
			cache_w_q <= rec_q.echo_width;
			cache_d_q <= quo_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= B_IDLE;
			cnt_q       <= '0;
			cache_vld_q <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			case (st_q)
				B_IDLE: begin
					if (start_div) begin
						cnt_q <= '0;
						st_q  <= B_DIV;
					end
				end
				B_DIV: begin
					if (div_busy) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (load_div) begin
						st_q <= B_IDLE;
					end
				end
				default: begin
					st_q <= B_IDLE;
				end
			endcase
			if (load_fast || load_div) begin
				out_vld_q <= 1'b1;
			end else if (pop) begin
				out_vld_q <= 1'b0;
			end
			if (cache_clr) begin
				cache_vld_q <= 1'b0;
			end else if (load_div) begin
				cache_vld_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/uer_checker.sv @@
// Port-level checker for the ultrasonic echo ranger, bound to the top level.
`default_nettype none
module uer_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          empty,
	input wire logic          pop,
	input wire uer_pkg::res_t res
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(res)))
		else $error("result changed while stalled");

	a_done_sets_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && res.done_pulse) |-> (res.complete_flag && !res.busy_res))
		else $error("finish without complete flag or still busy");

	a_timeout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && res.timed_out) |->
		(res.done_pulse && (res.echo_width == '0) && (res.distance == '0)))
		else $error("timeout result carries a width");

	a_trig_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && res.trigger_level) |-> res.busy_res)
		else $error("trigger high while idle");

	a_zero_dist: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (res.echo_width == '0)) |-> (res.distance == '0))
		else $error("distance without width");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.res    (res)
);
`default_nettype wire

@@ tb/ultrasonic_echo_ranger_tb.sv @@
// Testbench for the ultrasonic echo ranger: tick items in, every result checked by a predictor.
`timescale 1ns / 100ps
module ultrasonic_echo_ranger_tb;
	import uer_pkg::*;

	localparam int LIMIT = 500000;

	typedef enum logic [1:0] {PH_IDLE, PH_TRIG, PH_WAIT, PH_MEAS} phase_e;

	class ranger_scoreboard;
		logic [15:0]           tpc;
		logic [7:0]            trig_len;
		logic [15:0]           tmo_lim;
		phase_e                ph;
		logic [COUNT_BITS-1:0] tick_cnt;
		logic [COUNT_BITS-1:0] rise_at;
		logic [15:0]           width_q;
		logic [7:0]            trig_left;
		logic                  complete_q;
		res_t                  res_due[$];
		int                    mismatches;
		int                    checked;
		int                    echoes;
		int                    timeouts;

		function new();
			tpc        = TICKS_PER_CM_RST;
			trig_len   = TRIGGER_LENGTH_RST;
			tmo_lim    = TIMEOUT_LIMIT_RST;
			ph         = PH_IDLE;
			tick_cnt   = '0;
			rise_at    = '0;
			width_q    = '0;
			trig_left  = '0;
			complete_q = 1'b0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
				REG_TICKS_PER_CM:   tpc = val[15:0];
				REG_TRIGGER_LENGTH: trig_len = val[7:0];
				REG_TIMEOUT_LIMIT:  tmo_lim = val[15:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] reg_value(logic [1:0] idx);
			case (idx)
				REG_TICKS_PER_CM:   return {16'd0, tpc};
				REG_TRIGGER_LENGTH: return {24'd0, trig_len};
				default:            return {16'd0, tmo_lim};
			endcase
		endfunction

		function void note_tick(cmd_t c);
			res_t        r;
			logic [15:0] dv;
			logic        fin;
			logic        tmo;
			fin = 1'b0;
			tmo = 1'b0;
			if (c.abort_request) begin
				ph         = PH_IDLE;
				trig_left  = '0;
				complete_q = 1'b0;
			end else if (ph == PH_IDLE) begin
				if (c.start_request) begin
					complete_q = 1'b0;
					width_q    = '0;
					tick_cnt   = '0;
					rise_at    = '0;
					trig_left  = trig_len;
					ph         = PH_TRIG;
				end
			end else begin
				tick_cnt = tick_cnt + 1'b1;
				if (tick_cnt >= tmo_lim) begin
					ph         = PH_IDLE;
					trig_left  = '0;
					width_q    = '0;
					complete_q = 1'b1;
					fin        = 1'b1;
					tmo        = 1'b1;
				end else begin
					case (ph)
						PH_TRIG: begin
							if (trig_left <= 8'd1) begin
								trig_left = '0;
								ph        = PH_WAIT;
							end else begin
								trig_left = trig_left - 1'b1;
							end
						end
						PH_WAIT: begin
							if (c.echo_level) begin
								rise_at = tick_cnt;
								ph      = PH_MEAS;
							end
						end
						default: begin
							if (!c.echo_level) begin
								width_q    = 16'(tick_cnt - rise_at);
								ph         = PH_IDLE;
								complete_q = 1'b1;
								fin        = 1'b1;
							end
						end
					endcase
				end
			end
			dv              = (tpc == 16'd0) ? 16'd1 : tpc;
			r.trigger_level = (ph == PH_TRIG);
			r.busy_res      = (ph != PH_IDLE);
			r.done_pulse    = fin;
			r.timed_out     = tmo;
			r.complete_flag = complete_q;
			r.echo_width    = width_q;
			r.distance      = (width_q == 16'd0) ? 16'd0 : width_q / dv;
			res_due.push_back(r);
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= 30)
				$display("%0t mismatch: %s", $time, msg);
		endtask

		task cmp(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report($sformatf("result %0d %s got %0d want %0d", checked, name, got, want));
		endtask

		task check_result(res_t got);
			res_t want;
			if (res_due.size() == 0) begin
				report("result arrived with none pending");
				return;
			end
			want = res_due.pop_front();
			if (want.done_pulse) begin
				if (want.timed_out)
					timeouts++;
				else
					echoes++;
			end
			cmp("trigger_level", got.trigger_level, want.trigger_level);
			cmp("busy_res", got.busy_res, want.busy_res);
			cmp("done_pulse", got.done_pulse, want.done_pulse);
			cmp("timed_out", got.timed_out, want.timed_out);
			cmp("complete_flag", got.complete_flag, want.complete_flag);
			cmp("echo_width", got.echo_width, want.echo_width);
			cmp("distance", got.distance, want.distance);
			checked++;
		endtask
	endclass

	ranger_scoreboard   sb;
	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;
	logic               push;
	logic               full;
	cmd_t               cmd;
	logic               empty;
	logic               pop;
	res_t               res;
	int                 cycles = 0;
	int                 items_sent = 0;
	int                 settings_run = 0;
	bit                 tx_calm = 1'b0;
	bit                 rx_calm = 1'b0;
	bit                 hold_req = 1'b0;
	bit                 hold_rx = 1'b0;

	ultrasonic_echo_ranger u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.push    (push),
		.full    (full),
		.cmd     (cmd),
		.empty   (empty),
		.pop     (pop),
		.res     (res)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic bit coin();
		return 1'($urandom_range(0, 1));
	endfunction

	task automatic push_item(input cmd_t c);
		int gap;
		if ($urandom_range(0, 39) == 0)
			tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 14);
		repeat (gap) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push <= 1'b1;
		cmd  <= c;
		do @(posedge clk); while (full);
		sb.note_tick(c);
		items_sent++;
	endtask

	task automatic tick(input bit echo, input bit start, input bit abort_it);
		push_item({echo, start, abort_it});
	endtask

	task automatic drain_results();
		@(negedge clk);
		push <= 1'b0;
		while (sb.res_due.size() != 0)
			@(negedge clk);
	endtask

	task automatic check_reg(input logic [1:0] idx);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= PADDR_W'({idx, 2'b00});
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== sb.reg_value(idx))
			sb.report($sformatf("register %0d reads %0h want %0h", idx, prdata,
				sb.reg_value(idx)));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, val);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		check_reg(idx);
	endtask

	task automatic apply_cfg(input logic [15:0] tpc, input logic [7:0] trig,
		input logic [15:0] tmo);
		drain_results();
		reg_write(REG_TICKS_PER_CM, {16'd0, tpc});
		reg_write(REG_TRIGGER_LENGTH, {24'd0, trig});
		reg_write(REG_TIMEOUT_LIMIT, {16'd0, tmo});
		settings_run++;
	endtask

	task automatic measure(input int wait_n, input int hi_n);
		int trig_n;
		trig_n = (sb.trig_len == 8'd0) ? 1 : int'(sb.trig_len);
		tick(coin(), 1'b1, 1'b0);
		repeat (trig_n) tick(coin(), coin(), 1'b0);
		repeat (wait_n) tick(1'b0, coin(), 1'b0);
		repeat (hi_n) tick(1'b1, coin(), 1'b0);
		tick(1'b0, coin(), 1'b0);
	endtask

	task automatic broken_run();
		tick(coin(), 1'b1, 1'b0);
		repeat ($urandom_range(0, int'(sb.trig_len) + 10))
			tick(coin(), coin(), 1'b0);
		tick(coin(), coin(), 1'b1);
	endtask

	task automatic random_phase(input int n_items);
		int stop_at;
		int pick;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 19);
			if (sb.ph != PH_IDLE)
				tick(coin(), coin(), 1'b1);
			if (pick < 15)
				measure($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 40),
					($urandom_range(0, 7) == 0) ? $urandom_range(1, 400)
						: $urandom_range(1, 40));
			else if (pick < 17)
				broken_run();
			else
				repeat ($urandom_range(1, 8))
					tick(coin(), coin(), coin());
		end
	endtask

	initial begin
		hold_rx = 1'b0;
		wait (hold_req);
		hold_rx = 1'b1;
		repeat (400) @(posedge clk);
		hold_rx = 1'b0;
	end

	initial begin : result_side
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rx_calm = !rx_calm;
			stall = rx_calm ? 0 : $urandom_range(0, 14);
			repeat (stall) begin
				@(negedge clk);
				pop <= 1'b0;
			end
			while (hold_rx) begin
				@(negedge clk);
				pop <= 1'b0;
			end
			@(negedge clk);
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			sb.check_result(res);
		end
	end

	initial begin
		sb      = new();
		arst_n  = 1'b0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		push    = 1'b0;
		cmd     = '0;
		pop     = 1'b0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		check_reg(REG_TICKS_PER_CM);
		check_reg(REG_TRIGGER_LENGTH);
		check_reg(REG_TIMEOUT_LIMIT);
		tick(1'b0, 1'b0, 1'b0);
		tick(1'b1, 1'b0, 1'b1);
		tick(1'b0, 1'b1, 1'b1);

		// zero divisor, zero trigger length, zero timeout
		apply_cfg(16'd0, 8'd0, 16'd0);
		tick(1'b0, 1'b1, 1'b0);
		tick(1'b1, 1'b0, 1'b0);

		// echo high on entering wait, then abort clears the flag
		apply_cfg(16'd0, 8'd0, 16'hFFFF);
		tick(1'b0, 1'b1, 1'b0);
		tick(1'b1, 1'b1, 1'b0);
		tick(1'b1, 1'b0, 1'b0);
		tick(1'b1, 1'b0, 1'b0);
		tick(1'b1, 1'b0, 1'b0);
		tick(1'b0, 1'b0, 1'b0);
		tick(1'b1, 1'b0, 1'b1);

		// fall and timeout on the same tick, then abort during trigger
		apply_cfg(16'hFFFF, 8'd2, 16'd5);
		tick(1'b0, 1'b1, 1'b0);
		tick(1'b1, 1'b0, 1'b0);
		tick(1'b0, 1'b0, 1'b0);
		tick(1'b1, 1'b0, 1'b0);
		tick(1'b1, 1'b0, 1'b0);
		tick(1'b0, 1'b0, 1'b0);
		tick(1'b0, 1'b1, 1'b0);
		tick(1'b1, 1'b0, 1'b1);

		apply_cfg(TICKS_PER_CM_RST, TRIGGER_LENGTH_RST, TIMEOUT_LIMIT_RST);
		random_phase(100);
		apply_cfg(16'd1, 8'd1, 16'hFFFF);
		hold_req = 1'b1;
		random_phase(100);
		apply_cfg(16'hFFFF, 8'hFF, 16'hFFFF);
		random_phase(40);
		apply_cfg(16'd0, 8'd0, 16'd1);
		random_phase(60);
		repeat (4) begin
			apply_cfg(16'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
					: $urandom_range(1, 12)),
				8'($urandom_range(1, 30)), 16'($urandom_range(20, 200)));
			random_phase(80);
		end

		drain_results();
		repeat (40) @(posedge clk);
		$display("%0d tick items over %0d register settings: %0d echoes timed, %0d timeouts",
			items_sent, settings_run, sb.echoes, sb.timeouts);
		$display("%0d results compared, %0d mismatches", sb.checked, sb.mismatches);
		if (sb.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
